// ----- design/spe_pkg.sv -----
// ----------------------------------------------------------------------------
// spe_pkg
// Types and constants shared by the stack pattern eraser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package spe_pkg;

    localparam int DATA_W      = 8;
    localparam int RIDX_W      = 12;
    localparam int DEPTH_OUT_W = 13;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int PLEN_W      = 6;
    localparam int PIDX_W      = 5;
    localparam int PAT_BITS    = 256;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 24;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD0  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD1  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD2  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD3  = 3'd4;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUSH,
        ST_RD_ADDR,
        ST_RD_DATA,
        ST_CMP,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load_item;    // capture the accepted word
        logic push;         // write the byte, bump the count, compute the base
        logic push_pop;     // write the byte and erase it at once
        logic set_overflow;
        logic rd_item;      // drive the read index onto the memory
        logic capture_read;
        logic cmp_start;
        logic cmp_step;
        logic pop;          // drop the matched pattern
        logic out_load;
    } spe_cmd_t;

    typedef struct packed {
        logic full;
        logic hit;          // last pattern byte seen with enough entries
        logic len_one;
        logic cmp_last;
        logic cmp_mismatch;
    } spe_status_t;

    function automatic logic [DATA_W-1:0] pat_byte(input logic [PAT_BITS-1:0] bits,
                                                    input logic [PIDX_W-1:0]   idx);
        pat_byte = bits[{idx, 3'b000} +: DATA_W];
    endfunction

endpackage

`default_nettype wire

// ----- design/stack_pattern_eraser.sv -----
// A read passes through the address and data states, a push with no walk through the
// push state, to the result state. A push whose byte matches the last pattern byte,
// with enough entries and a pattern longer than one byte, walks the stack memory one
// entry a cycle over the pattern length. The walk is bound by the single read port of
// the stack memory; one item at a time. Synchronous active-low reset empties the stack
// and loads pattern length 1 and a zero pattern; the stack memory is not cleared.
// ----------------------------------------------------------------------------
// stack_pattern_eraser
// Byte stack that erases a configured pattern when a push completes it at the top.
// ----------------------------------------------------------------------------
`default_nettype none

module stack_pattern_eraser import spe_pkg::*; #(
    parameter int STACK_DEPTH = 4096,
    parameter int MAX_PATTERN = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // data_byte [7:0], read_index [19:8], zero [23:20]
    input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,
    // opcode [0]
    input  wire logic                  s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // stack_depth [12:0], erased [13], overflow [14], read_byte [22:15], is_empty [23]
    output logic      [M_TDATA_W-1:0]  m_axis_tdata
);

    spe_cmd_t    cmd;
    spe_status_t status;

    spe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_opcode (s_axis_tuser),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    spe_datapath #(
        .STACK_DEPTH (STACK_DEPTH),
        .MAX_PATTERN (MAX_PATTERN)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .in_data_byte  (s_axis_tdata[DATA_W-1:0]),
        .in_read_index (s_axis_tdata[DATA_W +: RIDX_W]),
        .cmd           (cmd),
        .status        (status),
        .m_tdata       (m_axis_tdata)
    );

endmodule

`default_nettype wire

// ----- design/spe_ram.sv -----
// ----------------------------------------------------------------------------
// spe_ram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module spe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ----- design/spe_ctrl.sv -----
// ----------------------------------------------------------------------------
// spe_ctrl
// Sequencer for push, pattern walk, read and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module spe_ctrl import spe_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_opcode,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    input  wire spe_status_t status,
    output spe_cmd_t         cmd
);

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = (s_opcode == OP_READ) ? ST_RD_ADDR : ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (!status.full && status.hit && !status.len_one) begin
                    state_next = ST_CMP;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_RD_ADDR: state_next = ST_RD_DATA;
            ST_RD_DATA: state_next = ST_OUT;
            ST_CMP: begin
                if (status.cmp_mismatch || status.cmp_last) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd          = '0;
        s_tready     = 1'b0;
        m_valid_next = m_valid_reg && !m_tready;
        case (state_reg)
            ST_IDLE: begin
                s_tready      = 1'b1;
                cmd.load_item = s_tvalid;
            end
            ST_PUSH: begin
                if (status.full) begin
                    cmd.set_overflow = 1'b1;
                end else if (status.hit && status.len_one) begin
                    cmd.push_pop = 1'b1;
                end else begin
                    cmd.push      = 1'b1;
                    cmd.cmp_start = status.hit;
                end
            end
            ST_RD_ADDR: cmd.rd_item = 1'b1;
            ST_RD_DATA: cmd.capture_read = 1'b1;
            ST_CMP: begin
                cmd.cmp_step = 1'b1;
                cmd.pop      = status.cmp_last && !status.cmp_mismatch;
            end
            ST_OUT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                end
            end
            default: cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- design/spe_datapath.sv -----
// ----------------------------------------------------------------------------
// spe_datapath
// Pattern registers, stack count, stack memory, compare walk and result word.
// ----------------------------------------------------------------------------
`default_nettype none

module spe_datapath import spe_pkg::*; #(
    parameter int STACK_DEPTH = 4096,
    parameter int MAX_PATTERN = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic [DATA_W-1:0]     in_data_byte,
    input  wire logic [RIDX_W-1:0]     in_read_index,
    input  wire spe_cmd_t              cmd,
    output spe_status_t                status,
    output logic      [M_TDATA_W-1:0]  m_tdata
);

    localparam int AW   = $clog2(STACK_DEPTH);
    localparam int CW   = $clog2(STACK_DEPTH + 1);
    localparam int CMPW = ((CW > RIDX_W) ? CW : RIDX_W) + 1;

    logic [PLEN_W-1:0]     plen_reg;
    logic [CFG_DATA_W-1:0] pword_reg [4];
    logic [PAT_BITS-1:0]   pat_bits;
    logic [PLEN_W-1:0]     len_eff;
    logic [PIDX_W-1:0]     len_m1;

    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         base_reg;
    logic [PIDX_W-1:0]     cmp_idx_reg;
    logic [DATA_W-1:0]     data_reg;
    logic [RIDX_W-1:0]     ridx_reg;
    logic                  erased_reg, overflow_reg;
    logic [DATA_W-1:0]     rbyte_reg;
    logic [M_TDATA_W-1:0]  tdata_reg;

    logic                  ram_wr_en;
    logic [AW-1:0]         ram_rd_addr;
    logic [DATA_W-1:0]     ram_rd_data;
    logic                  in_range;
    logic [CW:0]           count_inc;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plen_reg     <= PLEN_W'(1);
            pword_reg[0] <= '0;
            pword_reg[1] <= '0;
            pword_reg[2] <= '0;
            pword_reg[3] <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_PATTERN_LENGTH: plen_reg     <= cfg_wdata[PLEN_W-1:0];
                REG_PATTERN_WORD0:  pword_reg[0] <= cfg_wdata;
                REG_PATTERN_WORD1:  pword_reg[1] <= cfg_wdata;
                REG_PATTERN_WORD2:  pword_reg[2] <= cfg_wdata;
                REG_PATTERN_WORD3:  pword_reg[3] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign pat_bits = {pword_reg[3], pword_reg[2], pword_reg[1], pword_reg[0]};
    assign len_eff  = (plen_reg > PLEN_W'(MAX_PATTERN)) ? PLEN_W'(MAX_PATTERN) : plen_reg;
    assign len_m1   = PIDX_W'(len_eff - PLEN_W'(1));

    assign count_inc = {1'b0, count_reg} + (CW+1)'(1);

    // status towards the sequencer
    always_comb begin
        status.full     = (count_reg == CW'(STACK_DEPTH));
        status.hit      = (len_eff != '0) && (data_reg == pat_byte(pat_bits, len_m1))
                          && (count_inc >= (CW+1)'(len_eff));
        status.len_one  = (len_eff == PLEN_W'(1));
        status.cmp_last = (cmp_idx_reg == len_m1);
        status.cmp_mismatch = (cmp_idx_reg != '0) &&
            (ram_rd_data != pat_byte(pat_bits, PIDX_W'(cmp_idx_reg - PIDX_W'(1))));
    end

    // stack count and walk registers
    always_comb begin
        count_next = count_reg;
        if (cmd.push) begin
            count_next = CW'(count_inc);
        end else if (cmd.pop) begin
            count_next = base_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            data_reg     <= in_data_byte;
            ridx_reg     <= in_read_index;
            erased_reg   <= 1'b0;
            overflow_reg <= 1'b0;
            rbyte_reg    <= '0;
        end
        if (cmd.push) begin
            base_reg <= CW'(count_inc - (CW+1)'(len_eff));
        end
        if (cmd.cmp_start) begin
            cmp_idx_reg <= '0;
        end else if (cmd.cmp_step) begin
            cmp_idx_reg <= cmp_idx_reg + PIDX_W'(1);
        end
        if (cmd.push_pop || cmd.pop) begin
            erased_reg <= 1'b1;
        end
        if (cmd.set_overflow) begin
            overflow_reg <= 1'b1;
        end
        if (cmd.capture_read) begin
            rbyte_reg <= in_range ? ram_rd_data : '0;
        end
        if (cmd.out_load) begin
            tdata_reg <= {(count_reg == '0), rbyte_reg, overflow_reg, erased_reg,
                          DEPTH_OUT_W'(count_reg)};
        end
    end

    assign in_range = (CMPW'(ridx_reg) < CMPW'(count_reg)) &&
                      (CMPW'(ridx_reg) < CMPW'(STACK_DEPTH));

    // stack memory
    assign ram_wr_en   = cmd.push || cmd.push_pop;
    assign ram_rd_addr = cmd.rd_item ? AW'(ridx_reg) : AW'(base_reg + CW'(cmp_idx_reg));

    spe_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (AW'(count_reg)),
        .wr_data (data_reg),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign m_tdata = tdata_reg;

endmodule

`default_nettype wire
